@@ sv/hvue_pkg.sv @@
// Shared types and constants for the hypercube vertex update engine.
`timescale 1ns / 1ps
`default_nettype none

package hvue_pkg;

  // Action codes carried by an input beat
  localparam logic ACT_EXECUTE = 1'b0;
  localparam logic ACT_LOAD    = 1'b1;

  // Vertex kinds
  localparam int unsigned KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_NORMAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INPUT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OUTPUT = 2'd2;

  // Neighbor index width: the index bounces between 0 and ADDRESS_BITS-1
  localparam int unsigned IDX_W = 4;
  localparam int unsigned NB_OUT_W = 3;

  // Controller to datapath commands
  typedef struct packed {
    logic rd_self;  // input beat taken: latch it and read its own record
    logic rd_nb;    // own record is out: capture it and read the neighbor
    logic commit;   // write back the record and load the result register
  } hvue_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free; // result register can take a new beat this cycle
  } hvue_status_t;

endpackage

`default_nettype wire

@@ sv/hvue_ctrl.sv @@
// Controller state machine: sequences self read, neighbor read and write-back.
`timescale 1ns / 1ps
`default_nettype none

module hvue_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output hvue_pkg::hvue_cmd_t        cmd,
  input  wire hvue_pkg::hvue_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NBR,
    ST_EXEC
  } state_t;

  state_t state;

  // Input side waits while an item is in flight
  assign in_stall = (state != ST_IDLE);

  // Commands
  assign cmd.rd_self = in_valid && (state == ST_IDLE);
  assign cmd.rd_nb   = (state == ST_NBR);
  assign cmd.commit  = (state == ST_EXEC) && status.out_free;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_NBR;
        end
        ST_NBR: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/hvue_dpath.sv @@
// Datapath: vertex record store, update logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module hvue_dpath #(
  parameter int unsigned ADDRESS_BITS = 6,
  parameter int unsigned ENERGY_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire hvue_pkg::hvue_cmd_t                  cmd,
  output hvue_pkg::hvue_status_t                    status,
  input  wire logic                                 action,
  input  wire logic [ADDRESS_BITS-1:0]              vertex_addr,
  input  wire logic [hvue_pkg::KIND_W-1:0]          vertex_kind,
  input  wire logic                                 initial_state,
  input  wire logic                                 external_signal,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      vertex_state,
  output logic [ENERGY_BITS-1:0]                    vertex_energy,
  output logic                                      vertex_excited,
  output logic                                      output_fire,
  output logic [hvue_pkg::NB_OUT_W-1:0]             next_neighbor
);

  localparam int unsigned VCOUNT = 1 << ADDRESS_BITS;

  typedef struct packed {
    logic [hvue_pkg::KIND_W-1:0] kind;
    logic                        state;
    logic [ENERGY_BITS-1:0]      energy;
    logic [ENERGY_BITS-1:0]      upper;
    logic [ENERGY_BITS-1:0]      lower;
    logic                        excited;
    logic [hvue_pkg::IDX_W-1:0]  index;
    logic                        rising;
  } vrec_t;

  // Rest record for never-written entries
  localparam vrec_t REC_RESET = '{
    kind:    hvue_pkg::KIND_NORMAL,
    state:   1'b0,
    energy:  ENERGY_BITS'(1),
    upper:   ENERGY_BITS'(2),
    lower:   ENERGY_BITS'(1),
    excited: 1'b0,
    index:   '0,
    rising:  1'b1
  };

  // Store and its read register
  vrec_t                    mem [VCOUNT];
  logic  [VCOUNT-1:0]       written;
  vrec_t                    mem_q;
  logic                     written_q;
  vrec_t                    rd_view;
  logic  [ADDRESS_BITS-1:0] rd_addr;

  // Latched input beat and own record
  logic                        act_q;
  logic [ADDRESS_BITS-1:0]     addr_q;
  logic [hvue_pkg::KIND_W-1:0] kind_q;
  logic                        init_q;
  logic                        ext_q;
  vrec_t                       self_rec;

  // Update logic
  logic [ADDRESS_BITS-1:0] nb_addr;
  logic [ADDRESS_BITS-1:0] nb_flip;
  logic                    nb_exc;
  logic                    nb_st;
  logic [ENERGY_BITS:0]    e_inc;
  logic [ENERGY_BITS:0]    ul_sum;
  logic [ENERGY_BITS-1:0]  e_up;
  logic [ENERGY_BITS-1:0]  e_dn;
  logic [ENERGY_BITS-1:0]  u_up;
  logic [ENERGY_BITS-1:0]  l_dn;
  logic                    rise_b;
  vrec_t                   upd;
  vrec_t                   rec_next;
  logic                    fire_next;

  // Read view: unwritten entries read as rest record
  assign rd_view = written_q ? mem_q : REC_RESET;

  // Neighbor address from the own record just read
  assign nb_flip = ADDRESS_BITS'(1) << rd_view.index;
  assign nb_addr = (rd_view.index < hvue_pkg::IDX_W'(ADDRESS_BITS)) ?
                   (addr_q ^ nb_flip) : addr_q;

  assign rd_addr = cmd.rd_self ? vertex_addr : nb_addr;

  // Memory write and registered read; the neighbor record holds until write-back
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[addr_q] <= rec_next;
    end
    if (cmd.rd_self || cmd.rd_nb) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (cmd.commit) written[addr_q] <= 1'b1;
      if (cmd.rd_self || cmd.rd_nb) written_q <= written[rd_addr];
    end
  end

  // Input beat and own record capture
  always_ff @(posedge clk) begin
    if (cmd.rd_self) begin
      act_q  <= action;
      addr_q <= vertex_addr;
      kind_q <= vertex_kind;
      init_q <= initial_state;
      ext_q  <= external_signal;
    end
    if (cmd.rd_nb) begin
      self_rec <= rd_view;
    end
  end

  // Saturating sums and clamped differences
  assign e_inc  = {1'b0, self_rec.energy} + (ENERGY_BITS + 1)'(1);
  assign ul_sum = {1'b0, self_rec.upper} + {1'b0, self_rec.lower};
  assign e_up   = e_inc[ENERGY_BITS] ? '1 : e_inc[ENERGY_BITS-1:0];
  assign u_up   = ul_sum[ENERGY_BITS] ? '1 : ul_sum[ENERGY_BITS-1:0];
  assign e_dn   = (self_rec.energy != '0) ? self_rec.energy - ENERGY_BITS'(1) : '0;
  assign l_dn   = (self_rec.upper > self_rec.lower) ?
                  self_rec.upper - self_rec.lower : '0;

  // Neighbor view: input vertices see an excited virtual neighbor
  assign nb_exc = (self_rec.kind == hvue_pkg::KIND_INPUT) ? 1'b1 : rd_view.excited;
  assign nb_st  = (self_rec.kind == hvue_pkg::KIND_INPUT) ? ext_q : rd_view.state;

  // Vertex update
  always_comb begin
    upd = self_rec;
    if (nb_exc) begin
      if (nb_st == self_rec.state) begin
        upd.energy = e_up;
        if (e_up >= self_rec.upper) begin
          upd.excited = 1'b1;
          upd.upper   = u_up;
          upd.lower   = self_rec.upper;
        end
      end else begin
        upd.energy = e_dn;
        if (e_dn < self_rec.lower) begin
          upd.lower = l_dn;
          upd.upper = self_rec.lower;
        end
      end
    end
    // Energy exhausted: flip state and restart thresholds
    if (upd.energy == '0) begin
      upd.state  = ~self_rec.state;
      upd.energy = ENERGY_BITS'(1);
      upd.upper  = ENERGY_BITS'(2);
      upd.lower  = ENERGY_BITS'(1);
    end
    // Bounce the neighbor index between 0 and ADDRESS_BITS-1
    rise_b = (self_rec.index == '0) ? 1'b1 : self_rec.rising;
    if (self_rec.index == hvue_pkg::IDX_W'(ADDRESS_BITS - 1) && rise_b) begin
      rise_b = 1'b0;
    end
    upd.rising = rise_b;
    upd.index  = rise_b ? self_rec.index + hvue_pkg::IDX_W'(1)
                        : self_rec.index - hvue_pkg::IDX_W'(1);
  end

  // Select load, excited skip or full update
  always_comb begin
    rec_next  = upd;
    fire_next = 1'b0;
    if (act_q == hvue_pkg::ACT_LOAD) begin
      rec_next       = REC_RESET;
      rec_next.kind  = kind_q;
      rec_next.state = init_q;
    end else if (self_rec.excited) begin
      rec_next         = self_rec;
      rec_next.excited = 1'b0;
    end else begin
      fire_next = (self_rec.kind == hvue_pkg::KIND_OUTPUT) &&
                  (upd.energy >= ENERGY_BITS'(2));
    end
  end

  // Result register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      vertex_state   <= rec_next.state;
      vertex_energy  <= rec_next.energy;
      vertex_excited <= rec_next.excited;
      output_fire    <= fire_next;
      next_neighbor  <= rec_next.index[hvue_pkg::NB_OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ sv/hypercube_vertex_update_engine.sv @@
// Top level of the hypercube vertex update engine.
`timescale 1ns / 1ps
`default_nettype none

// Keeps one record per vertex of a 2^ADDRESS_BITS hypercube in a single-port
// store. A load beat sets a vertex's kind and state and rests the record; an
// execute beat updates the vertex against one neighbor and writes it back, or
// only clears the excitation of an excited vertex. Every beat gives one result
// beat. The own record is read at acceptance, the neighbor record whose
// address follows from it in the next cycle, and the record is written back
// and the result register loaded once that register is free. The input is
// stalled until the write-back, so one item is in flight at a time. The result
// register lets the next item be taken while the previous result waits; that
// item then holds at write-back until the result is taken. Reset marks every
// vertex as resting at once; no clearing pass is needed.
module hypercube_vertex_update_engine #(
  parameter int unsigned ADDRESS_BITS = 6,
  parameter int unsigned ENERGY_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         action,
  input  wire logic [ADDRESS_BITS-1:0]      vertex_addr,
  input  wire logic [hvue_pkg::KIND_W-1:0]  vertex_kind,
  input  wire logic                         initial_state,
  input  wire logic                         external_signal,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              vertex_state,
  output logic [ENERGY_BITS-1:0]            vertex_energy,
  output logic                              vertex_excited,
  output logic                              output_fire,
  output logic [hvue_pkg::NB_OUT_W-1:0]     next_neighbor
);

  hvue_pkg::hvue_cmd_t    cmd;
  hvue_pkg::hvue_status_t status;

  hvue_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  hvue_dpath #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .ENERGY_BITS  (ENERGY_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .action          (action),
    .vertex_addr     (vertex_addr),
    .vertex_kind     (vertex_kind),
    .initial_state   (initial_state),
    .external_signal (external_signal),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .vertex_state    (vertex_state),
    .vertex_energy   (vertex_energy),
    .vertex_excited  (vertex_excited),
    .output_fire     (output_fire),
    .next_neighbor   (next_neighbor)
  );

endmodule

`default_nettype wire

@@ sv/hvue_checker.sv @@
// Port-level checks for the hypercube vertex update engine, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module hvue_checker #(
  parameter int unsigned ADDRESS_BITS = 6,
  parameter int unsigned ENERGY_BITS  = 16
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         action,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         vertex_state,
  input wire logic [ENERGY_BITS-1:0]       vertex_energy,
  input wire logic                         vertex_excited,
  input wire logic                         output_fire,
  input wire logic [hvue_pkg::NB_OUT_W-1:0] next_neighbor
);

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  // A stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(vertex_energy) && $stable(vertex_state)
      && $stable(next_neighbor))
    else $error("result payload changed while stalled");

  // Only one item in flight: input stalls right after a beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> in_stall)
    else $error("second input beat taken while busy");

  // A load into an empty result register reports a resting record
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    in_beat && (action == hvue_pkg::ACT_LOAD) && !out_valid |=> ##2
      out_valid && (vertex_energy == ENERGY_BITS'(1)) && !vertex_excited
      && !output_fire && (next_neighbor == '0))
    else $error("load beat gave wrong or late result");

  // Firing needs energy of at least two
  a_fire_energy: assert property (@(posedge clk) disable iff (rst)
    out_valid && output_fire |-> vertex_energy >= ENERGY_BITS'(2))
    else $error("output fired with low energy");

endmodule

bind hypercube_vertex_update_engine hvue_checker #(
  .ADDRESS_BITS (ADDRESS_BITS),
  .ENERGY_BITS  (ENERGY_BITS)
) u_hvue_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .action         (action),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .vertex_state   (vertex_state),
  .vertex_energy  (vertex_energy),
  .vertex_excited (vertex_excited),
  .output_fire    (output_fire),
  .next_neighbor  (next_neighbor)
);

`default_nettype wire

@@ tb/hypercube_vertex_update_engine_test.sv @@
// Self-checking testbench for the hypercube vertex update engine.
`timescale 1ns / 1ps

module hypercube_vertex_update_engine_test;

  localparam int unsigned ADDRESS_BITS = 6;
  localparam int unsigned ENERGY_BITS  = 16;
  localparam int unsigned VERTEX_COUNT = 1 << ADDRESS_BITS;
  localparam longint unsigned ENERGY_MAX = (64'd1 << ENERGY_BITS) - 1;

  // One reported vertex as it leaves the block
  typedef struct {
    logic                          state;
    logic [ENERGY_BITS-1:0]        energy;
    logic                          excited;
    logic                          fire;
    logic [hvue_pkg::NB_OUT_W-1:0] nb;
  } vertex_report_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          action = hvue_pkg::ACT_EXECUTE;
  logic [ADDRESS_BITS-1:0]       vertex_addr = '0;
  logic [hvue_pkg::KIND_W-1:0]   vertex_kind = hvue_pkg::KIND_NORMAL;
  logic                          initial_state = 1'b0;
  logic                          external_signal = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          vertex_state;
  logic [ENERGY_BITS-1:0]        vertex_energy;
  logic                          vertex_excited;
  logic                          output_fire;
  logic [hvue_pkg::NB_OUT_W-1:0] next_neighbor;

  hypercube_vertex_update_engine #(
    .ADDRESS_BITS(ADDRESS_BITS),
    .ENERGY_BITS (ENERGY_BITS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .vertex_addr    (vertex_addr),
    .vertex_kind    (vertex_kind),
    .initial_state  (initial_state),
    .external_signal(external_signal),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .vertex_state   (vertex_state),
    .vertex_energy  (vertex_energy),
    .vertex_excited (vertex_excited),
    .output_fire    (output_fire),
    .next_neighbor  (next_neighbor)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the vertex store
  logic [hvue_pkg::KIND_W-1:0] vx_kind    [VERTEX_COUNT];
  logic                        vx_state   [VERTEX_COUNT];
  int unsigned                 vx_energy  [VERTEX_COUNT];
  int unsigned                 vx_upper   [VERTEX_COUNT];
  int unsigned                 vx_lower   [VERTEX_COUNT];
  logic                        vx_excited [VERTEX_COUNT];
  logic [hvue_pkg::IDX_W-1:0]  vx_index   [VERTEX_COUNT];
  logic                        vx_rising  [VERTEX_COUNT];

  vertex_report_t pending_reports[$];
  int unsigned    mismatch_count = 0;
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_idle_pct = 0;

  function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > ENERGY_MAX) ? 32'(ENERGY_MAX) : 32'(s);
  endfunction

  function automatic void rest_vertex(int unsigned a);
    vx_energy[a]  = 1;
    vx_upper[a]   = 2;
    vx_lower[a]   = 1;
    vx_excited[a] = 1'b0;
    vx_index[a]   = '0;
    vx_rising[a]  = 1'b1;
  endfunction

  function automatic void clear_vertex_store();
    for (int unsigned a = 0; a < VERTEX_COUNT; a++) begin
      vx_kind[a]  = hvue_pkg::KIND_NORMAL;
      vx_state[a] = 1'b0;
      rest_vertex(a);
    end
  endfunction

  function automatic vertex_report_t snapshot(int unsigned a, logic fire);
    vertex_report_t r;
    r.state   = vx_state[a];
    r.energy  = vx_energy[a][ENERGY_BITS-1:0];
    r.excited = vx_excited[a];
    r.fire    = fire;
    r.nb      = vx_index[a][hvue_pkg::NB_OUT_W-1:0];
    return r;
  endfunction

  // Apply one accepted beat to the shadow store and return the vertex report
  function automatic vertex_report_t update_vertex(logic act, logic [ADDRESS_BITS-1:0] addr,
                                                   logic [hvue_pkg::KIND_W-1:0] kind,
                                                   logic init, logic ext);
    int unsigned a;
    int unsigned na;
    logic        nb_exc;
    logic        nb_st;
    int unsigned keep;
    a = 32'(addr);
    if (act == hvue_pkg::ACT_LOAD) begin
      vx_kind[a]  = kind;
      vx_state[a] = init;
      rest_vertex(a);
      return snapshot(a, 1'b0);
    end
    if (vx_excited[a]) begin
      vx_excited[a] = 1'b0;
      return snapshot(a, 1'b0);
    end
    // neighbor probe; input vertices see a virtual excited vertex
    if (vx_kind[a] == hvue_pkg::KIND_INPUT) begin
      nb_exc = 1'b1;
      nb_st  = ext;
    end else begin
      na = a;
      if (vx_index[a] < ADDRESS_BITS) na = a ^ (32'd1 << vx_index[a]);
      nb_exc = vx_excited[na];
      nb_st  = vx_state[na];
    end
    if (nb_exc) begin
      if (nb_st == vx_state[a]) begin
        vx_energy[a] = sat_sum(vx_energy[a], 1);
        if (vx_energy[a] >= vx_upper[a]) begin
          keep = vx_upper[a];
          vx_excited[a] = 1'b1;
          vx_upper[a] = sat_sum(vx_upper[a], vx_lower[a]);
          vx_lower[a] = keep;
        end
      end else begin
        if (vx_energy[a] > 0) vx_energy[a]--;
        if (vx_energy[a] < vx_lower[a]) begin
          keep = vx_lower[a];
          vx_lower[a] = (vx_upper[a] > vx_lower[a]) ? vx_upper[a] - vx_lower[a] : 0;
          vx_upper[a] = keep;
        end
      end
    end
    // empty vertex flips and restarts its thresholds
    if (vx_energy[a] == 0) begin
      vx_state[a]  = ~vx_state[a];
      vx_energy[a] = 1;
      vx_upper[a]  = 2;
      vx_lower[a]  = 1;
    end
    // neighbor index bounces between 0 and ADDRESS_BITS-1
    if (vx_index[a] == 0) vx_rising[a] = 1'b1;
    if (vx_index[a] == ADDRESS_BITS - 1 && vx_rising[a]) vx_rising[a] = 1'b0;
    vx_index[a] = vx_rising[a] ? vx_index[a] + 1'b1 : vx_index[a] - 1'b1;
    return snapshot(a, (vx_kind[a] == hvue_pkg::KIND_OUTPUT) && (vx_energy[a] >= 2));
  endfunction

  // Drive one beat, wait for it to be taken, then record what it must produce
  task automatic push_beat(logic act, logic [ADDRESS_BITS-1:0] addr,
                           logic [hvue_pkg::KIND_W-1:0] kind, logic init, logic ext);
    vertex_report_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= act;
    vertex_addr     <= addr;
    vertex_kind     <= kind;
    initial_state   <= init;
    external_signal <= ext;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    r = update_vertex(act, addr, kind, init, ext);
    pending_reports.push_back(r);
  endtask

  task automatic load_vertex(logic [ADDRESS_BITS-1:0] addr, logic [hvue_pkg::KIND_W-1:0] kind,
                             logic init);
    push_beat(hvue_pkg::ACT_LOAD, addr, kind, init, 1'($urandom_range(1)));
  endtask

  task automatic exec_vertex(logic [ADDRESS_BITS-1:0] addr, logic ext);
    push_beat(hvue_pkg::ACT_EXECUTE, addr, hvue_pkg::KIND_W'($urandom_range(3)),
              1'($urandom_range(1)), ext);
  endtask

  // Hold the input off until every pending report has come back
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall, checked on the falling edge
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string field, longint unsigned got, longint unsigned want);
    if (got !== want)
      note_failure($sformatf("%s expected %0d got %0d", field, want, got));
  endtask

  always @(negedge clk) begin : check_results
    vertex_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        note_failure("result beat with nothing pending");
      end else begin
        want = pending_reports.pop_front();
        if ({vertex_state, vertex_energy, vertex_excited, output_fire, next_neighbor} !==
            {want.state, want.energy, want.excited, want.fire, want.nb}) begin
          check_field("vertex_state", 64'(vertex_state), 64'(want.state));
          check_field("vertex_energy", 64'(vertex_energy), 64'(want.energy));
          check_field("vertex_excited", 64'(vertex_excited), 64'(want.excited));
          check_field("output_fire", 64'(output_fire), 64'(want.fire));
          check_field("next_neighbor", 64'(next_neighbor), 64'(want.nb));
        end
      end
    end
  end

  // Loads: every kind, kind three included, both state values, end addresses
  task automatic test_load_report();
    load_vertex(6'd0, hvue_pkg::KIND_INPUT, 1'b0);
    load_vertex(6'd1, hvue_pkg::KIND_OUTPUT, 1'b0);
    load_vertex(6'd2, 2'd3, 1'b1);
    load_vertex(6'd63, hvue_pkg::KIND_NORMAL, 1'b1);
  endtask

  // Input vertex excites off its virtual neighbor, output vertex fires off the excited input vertex
  task automatic test_excite_and_fire();
    exec_vertex(6'd0, 1'b0);
    exec_vertex(6'd1, 1'b0);
  endtask

  // Kind-three vertex probes the excited vertex with opposite state and flips
  task automatic test_state_flip();
    exec_vertex(6'd2, 1'b1);
    exec_vertex(6'd2, 1'b1);
  endtask

  // Excited vertices only drop their excitation
  task automatic test_excited_clear();
    exec_vertex(6'd1, 1'b0);
    exec_vertex(6'd0, 1'b0);
  endtask

  // Mismatch on the input vertex drops energy below the lower threshold
  task automatic test_fall_below_lower();
    exec_vertex(6'd0, 1'b1);
  endtask

  // Neighbor index rises to its top and turns back on a quiet vertex
  task automatic test_neighbor_bounce();
    for (int i = 0; i < 7; i++) exec_vertex(6'd63, i[0]);
  endtask

  // Input vertex paired with one neighbor across a random dimension, plus noise
  task automatic test_random_traffic(int unsigned count);
    int unsigned             sent;
    int unsigned             len;
    logic [ADDRESS_BITS-1:0] base;
    logic [ADDRESS_BITS-1:0] peer;
    logic                    st;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 20) begin
        push_beat(1'($urandom_range(1)), ADDRESS_BITS'($urandom_range(VERTEX_COUNT - 1)),
                  hvue_pkg::KIND_W'($urandom_range(3)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        sent++;
      end else begin
        base = ADDRESS_BITS'($urandom_range(VERTEX_COUNT - 1));
        peer = base ^ ADDRESS_BITS'(32'd1 << $urandom_range(ADDRESS_BITS - 1));
        st   = 1'($urandom_range(1));
        load_vertex(base, hvue_pkg::KIND_INPUT, st);
        load_vertex(peer, $urandom_range(1) ? hvue_pkg::KIND_OUTPUT : hvue_pkg::KIND_NORMAL,
                    ($urandom_range(9) < 7) ? st : ~st);
        sent += 2;
        len = $urandom_range(30, 8);
        repeat (len) begin
          if ($urandom_range(2) == 0) begin
            exec_vertex(peer, 1'($urandom_range(1)));
          end else begin
            exec_vertex(base, ($urandom_range(9) < 8) ? vx_state[base] : ~vx_state[base]);
          end
          sent++;
        end
        if ($urandom_range(9) == 0) drain_reports();
      end
    end
  endtask

  initial begin
    clear_vertex_store();
    tx_idle_pct = 37;
    rx_idle_pct = 87;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_load_report();
    test_excite_and_fire();
    test_state_flip();
    test_excited_clear();
    test_fall_below_lower();
    test_neighbor_bounce();
    drain_reports();

    test_random_traffic(230);
    drain_reports();
    tx_idle_pct = 87;
    rx_idle_pct = 37;
    test_random_traffic(230);
    drain_reports();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(230);
    drain_reports();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
